/* hdl/kts_pkg.sv */
// Shared types, widths and codes of the keyframe track sampler.
`timescale 1ns / 1ps
`default_nettype none

package kts_pkg;

    // Table geometry
    localparam int MaxKeys     = 32;
    localparam int AddrW       = $clog2(MaxKeys);
    localparam int CountW      = $clog2(MaxKeys + 1);

    // Field widths
    localparam int TimeW       = 32;
    localparam int KindW       = 3;
    localparam int DocW        = 16;
    localparam int StatusW     = 2;
    localparam int MixW        = 16;
    localparam int MixFracBits = 16;

    // Stream packing, rounded up to whole bytes
    localparam int InFieldsW   = TimeW + KindW + DocW;
    localparam int InDataW     = ((InFieldsW + 7) / 8) * 8;
    localparam int OutFieldsW  = DocW + 1 + DocW + KindW + MixW;
    localparam int OutDataW    = ((OutFieldsW + 7) / 8) * 8;

    // Operation code carried in tuser
    localparam logic ModeInsert = 1'b0;

    // Status codes
    localparam logic [StatusW-1:0] StOk    = 2'd0;
    localparam logic [StatusW-1:0] StFull  = 2'd1;
    localparam logic [StatusW-1:0] StEmpty = 2'd2;

    // Transition codes
    localparam logic [KindW-1:0] TrHold     = 3'd0;
    localparam logic [KindW-1:0] TrCut      = 3'd1;
    localparam logic [KindW-1:0] TrXfade    = 3'd2;
    localparam logic [KindW-1:0] TrScramble = 3'd3;
    localparam logic [KindW-1:0] TrMorph    = 3'd4;

    // One stored keyframe
    typedef struct packed {
        logic [DocW-1:0]         doc;
        logic [KindW-1:0]        kind;
        logic signed [TimeW-1:0] ftime;
    } entry_t;

    localparam int EntryW = $bits(entry_t);

    // One input item
    typedef struct packed {
        logic                    mode;
        logic signed [TimeW-1:0] ftime;
        logic [KindW-1:0]        kind;
        logic [DocW-1:0]         doc;
    } item_t;

    // One result item
    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [DocW-1:0]    active_doc;
        logic               from_valid;
        logic [DocW-1:0]    from_doc;
        logic [KindW-1:0]   transition;
        logic [MixW-1:0]    mix_q16;
    } result_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_DIV,
        S_RESULT
    } state_t;

endpackage

`default_nettype wire

/* hdl/keyframe_track_sampler_top.sv */
// Top level of the keyframe track sampler: stream ports and output register.
// An insert runs a linear scan of the table memory over the N keyframes held, then moves
// each entry above the insert point up one place; a sample runs a scan of up to N
// entries, then waits on the bit-serial mix divider.
// Throughput: one item at a time; the next transfer is taken once the result is in the
// output register, which may still wait on the downstream side.
// Reset clears the keyframe count and the control state; table memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_track_sampler_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // frame_time [31:0], transition_kind [34:32], document_id [50:35], zero pad
    input  wire logic [kts_pkg::InDataW-1:0]   s_axis_tdata,
    // mode [0]
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // active_doc [15:0], from_valid [16], from_doc [32:17], transition [35:33],
    // mix_q16 [51:36], zero pad
    output logic      [kts_pkg::OutDataW-1:0]  m_axis_tdata,
    // status [1:0]
    output logic      [kts_pkg::StatusW-1:0]   m_axis_tuser
);

    localparam int KindLo = kts_pkg::TimeW;
    localparam int DocLo  = kts_pkg::TimeW + kts_pkg::KindW;

    kts_pkg::item_t   item;
    kts_pkg::result_t res;
    kts_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             res_valid;
    logic             res_take;

    // Unpack the input transfer
    assign item.mode  = s_axis_tuser;
    assign item.ftime = s_axis_tdata[kts_pkg::TimeW-1:0];
    assign item.kind  = s_axis_tdata[KindLo +: kts_pkg::KindW];
    assign item.doc   = s_axis_tdata[DocLo +: kts_pkg::DocW];

    // Output slot is free when empty or draining this cycle
    assign res_take = !out_valid_reg || m_axis_tready;

    kts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .item      (item),
        .in_ready  (s_axis_tready),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // Hold the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_reg <= res;
        end
    end

    // Pack the output transfer
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = kts_pkg::OutDataW'({out_reg.mix_q16, out_reg.transition,
                                               out_reg.from_doc, out_reg.from_valid,
                                               out_reg.active_doc});

endmodule

`default_nettype wire

/* hdl/kts_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kts_ram #(
    parameter int Depth = 32,
    parameter int AddrW = $clog2(Depth),
    parameter int DataW = 8
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [DataW-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [DataW-1:0] rd_data
);

    logic [DataW-1:0] mem [Depth];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/kts_div.sv */
// Bit-serial restoring divider for the fractional mix.
`timescale 1ns / 1ps
`default_nettype none

module kts_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [kts_pkg::TimeW-1:0]    num,
    input  wire logic [kts_pkg::TimeW-1:0]    den,
    output logic                              busy,
    output logic      [kts_pkg::MixW-1:0]     quot
);

    localparam int CntW = $clog2(kts_pkg::MixFracBits + 1);
    localparam int WideW = kts_pkg::MixFracBits + kts_pkg::MixW;

    logic [CntW-1:0]                 cnt_reg, cnt_next;
    logic [kts_pkg::TimeW-1:0]       rem_reg, rem_next;
    logic [kts_pkg::TimeW-1:0]       den_reg, den_next;
    logic [kts_pkg::MixFracBits-1:0] q_reg, q_next;
    logic [kts_pkg::TimeW:0]         rem_sh;
    logic [kts_pkg::TimeW:0]         rem_sub;
    logic [WideW-1:0]                q_wide;
    logic [WideW-1:0]                q_lim;

    // Clamp the quotient to the output width
    assign q_wide = {{kts_pkg::MixW{1'b0}}, q_reg};
    assign q_lim  = {{kts_pkg::MixFracBits{1'b0}}, {kts_pkg::MixW{1'b1}}};
    assign quot   = (q_wide > q_lim) ? {kts_pkg::MixW{1'b1}} : q_wide[kts_pkg::MixW-1:0];
    assign busy   = (cnt_reg != '0);

    // One quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, 1'b0};
        rem_sub  = rem_sh - {1'b0, den_reg};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        q_next   = q_reg;
        if (start)
        begin
            cnt_next = CntW'(kts_pkg::MixFracBits);
            rem_next = num;
            den_next = den;
            q_next   = '0;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - CntW'(1);
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[kts_pkg::TimeW-1:0];
                q_next   = {q_reg[kts_pkg::MixFracBits-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[kts_pkg::TimeW-1:0];
                q_next   = {q_reg[kts_pkg::MixFracBits-2:0], 1'b0};
            end
        end
    end

    // Hold the iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

endmodule

`default_nettype wire

/* hdl/kts_ctrl.sv */
// Sequencer that scans, shifts and samples the keyframe table in memory.
`timescale 1ns / 1ps
`default_nettype none

module kts_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire kts_pkg::item_t   item,
    output logic                  in_ready,
    output logic                  res_valid,
    input  wire logic             res_take,
    output kts_pkg::result_t      res
);

    kts_pkg::state_t                 state_reg, state_next;
    logic [kts_pkg::CountW-1:0]      count_reg, count_next;
    logic                            op_reg, op_next;
    logic signed [kts_pkg::TimeW-1:0] t_reg, t_next;
    logic [kts_pkg::KindW-1:0]       kind_reg, kind_next;
    logic [kts_pkg::DocW-1:0]        doc_reg, doc_next;
    logic [kts_pkg::AddrW-1:0]       scan_reg, scan_next;
    logic [kts_pkg::AddrW-1:0]       shift_reg, shift_next;
    logic [kts_pkg::AddrW-1:0]       pos_reg, pos_next;
    kts_pkg::entry_t                 prev_reg, prev_next;
    kts_pkg::result_t                res_reg, res_next;

    logic                            rd_en;
    logic [kts_pkg::AddrW-1:0]       rd_addr;
    logic [kts_pkg::EntryW-1:0]      rd_data;
    logic                            wr_en;
    logic [kts_pkg::AddrW-1:0]       wr_addr;
    kts_pkg::entry_t                 wr_entry;
    kts_pkg::entry_t                 cur;
    kts_pkg::entry_t                 new_entry;

    logic [kts_pkg::CountW-1:0]      scan_inc;
    logic [kts_pkg::CountW-1:0]      count_dec;
    logic [kts_pkg::AddrW-1:0]       shift_dec;
    logic [kts_pkg::AddrW-1:0]       shift_dec2;
    logic                            last;
    logic                            full;
    logic [kts_pkg::TimeW:0]         gap_w;
    logic [kts_pkg::TimeW:0]         pos_w;
    logic                            div_start;
    logic                            div_busy;
    logic [kts_pkg::MixW-1:0]        div_quot;

    kts_ram #(
        .Depth (kts_pkg::MaxKeys),
        .AddrW (kts_pkg::AddrW),
        .DataW (kts_pkg::EntryW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (pos_w[kts_pkg::TimeW-1:0]),
        .den   (gap_w[kts_pkg::TimeW-1:0]),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Derived indexes and the interval arithmetic
    assign cur        = kts_pkg::entry_t'(rd_data);
    assign new_entry  = '{doc: doc_reg, kind: kind_reg, ftime: t_reg};
    assign scan_inc   = kts_pkg::CountW'(scan_reg) + kts_pkg::CountW'(1);
    assign count_dec  = count_reg - kts_pkg::CountW'(1);
    assign shift_dec  = shift_reg - kts_pkg::AddrW'(1);
    assign shift_dec2 = shift_reg - kts_pkg::AddrW'(2);
    assign last       = (scan_inc == count_reg);
    assign full       = (count_reg == kts_pkg::CountW'(kts_pkg::MaxKeys));
    assign gap_w      = {cur.ftime[kts_pkg::TimeW-1], cur.ftime}
                      - {prev_reg.ftime[kts_pkg::TimeW-1], prev_reg.ftime};
    assign pos_w      = {t_reg[kts_pkg::TimeW-1], t_reg}
                      - {prev_reg.ftime[kts_pkg::TimeW-1], prev_reg.ftime};

    assign res = res_reg;

    // Next state, memory accesses and result assembly
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        op_next    = op_reg;
        t_next     = t_reg;
        kind_next  = kind_reg;
        doc_next   = doc_reg;
        scan_next  = scan_reg;
        shift_next = shift_reg;
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_entry   = new_entry;
        div_start  = 1'b0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            kts_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next   = item.mode;
                    t_next    = item.ftime;
                    kind_next = item.kind;
                    doc_next  = item.doc;
                    res_next  = '0;
                    scan_next = '0;
                    if (count_reg == '0)
                    begin
                        // Empty table: an insert goes straight in, a sample reports empty
                        if (item.mode == kts_pkg::ModeInsert)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_entry   = '{doc: item.doc, kind: item.kind, ftime: item.ftime};
                            count_next = kts_pkg::CountW'(1);
                            res_next.status = kts_pkg::StOk;
                        end
                        else
                        begin
                            res_next.status = kts_pkg::StEmpty;
                        end
                        state_next = kts_pkg::S_RESULT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = kts_pkg::S_SCAN;
                    end
                end
            end

            kts_pkg::S_SCAN:
            begin
                if (op_reg == kts_pkg::ModeInsert)
                begin
                    if (cur.ftime < t_reg)
                    begin
                        if (last)
                        begin
                            // Append after the last entry, unless the table is full
                            if (full)
                            begin
                                res_next.status = kts_pkg::StFull;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[kts_pkg::AddrW-1:0];
                                count_next = count_reg + kts_pkg::CountW'(1);
                                res_next.status = kts_pkg::StOk;
                            end
                            state_next = kts_pkg::S_RESULT;
                        end
                        else
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = scan_inc[kts_pkg::AddrW-1:0];
                            scan_next = scan_inc[kts_pkg::AddrW-1:0];
                        end
                    end
                    else if (cur.ftime == t_reg)
                    begin
                        // Overwrite the entry with the same time
                        wr_en      = 1'b1;
                        wr_addr    = scan_reg;
                        res_next.status = kts_pkg::StOk;
                        state_next = kts_pkg::S_RESULT;
                    end
                    else if (full)
                    begin
                        res_next.status = kts_pkg::StFull;
                        state_next = kts_pkg::S_RESULT;
                    end
                    else
                    begin
                        // Open a gap: move entries up from the top down
                        pos_next   = scan_reg;
                        shift_next = count_reg[kts_pkg::AddrW-1:0];
                        rd_en      = 1'b1;
                        rd_addr    = count_dec[kts_pkg::AddrW-1:0];
                        state_next = kts_pkg::S_SHIFT;
                    end
                end
                else
                begin
                    if (cur.ftime <= t_reg)
                    begin
                        prev_next = cur;
                        if (last)
                        begin
                            // At or after the last keyframe
                            res_next.active_doc = cur.doc;
                            res_next.transition = kts_pkg::TrHold;
                            state_next = kts_pkg::S_RESULT;
                        end
                        else
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = scan_inc[kts_pkg::AddrW-1:0];
                            scan_next = scan_inc[kts_pkg::AddrW-1:0];
                        end
                    end
                    else if (scan_reg == '0)
                    begin
                        // Before the first keyframe
                        res_next.active_doc = cur.doc;
                        res_next.transition = kts_pkg::TrHold;
                        state_next = kts_pkg::S_RESULT;
                    end
                    else
                    begin
                        state_next = kts_pkg::S_RESULT;
                        case (prev_reg.kind) inside
                            kts_pkg::TrCut:
                            begin
                                res_next.active_doc = cur.doc;
                                res_next.transition = kts_pkg::TrCut;
                            end
                            kts_pkg::TrXfade, kts_pkg::TrScramble, kts_pkg::TrMorph:
                            begin
                                res_next.active_doc = cur.doc;
                                res_next.from_valid = 1'b1;
                                res_next.from_doc   = prev_reg.doc;
                                res_next.transition = prev_reg.kind;
                                div_start  = 1'b1;
                                state_next = kts_pkg::S_DIV;
                            end
                            default:
                            begin
                                res_next.active_doc = prev_reg.doc;
                                res_next.transition = kts_pkg::TrHold;
                            end
                        endcase
                    end
                end
            end

            kts_pkg::S_SHIFT:
            begin
                // Write the entry read last cycle one place up
                wr_en    = 1'b1;
                wr_addr  = shift_reg;
                wr_entry = cur;
                if (shift_dec == pos_reg)
                begin
                    state_next = kts_pkg::S_PUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = shift_dec2;
                    shift_next = shift_dec;
                end
            end

            kts_pkg::S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                count_next = count_reg + kts_pkg::CountW'(1);
                res_next.status = kts_pkg::StOk;
                state_next = kts_pkg::S_RESULT;
            end

            kts_pkg::S_DIV:
            begin
                if (!div_busy)
                begin
                    res_next.mix_q16 = div_quot;
                    state_next = kts_pkg::S_RESULT;
                end
            end

            kts_pkg::S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = kts_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = kts_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kts_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Item and working registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        t_reg     <= t_next;
        kind_reg  <= kind_next;
        doc_reg   <= doc_next;
        scan_reg  <= scan_next;
        shift_reg <= shift_next;
        pos_reg   <= pos_next;
        prev_reg  <= prev_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire
